// ----- hdl/dapi_pkg.sv -----
// shared types and constants of the decimal text to integer parser
`timescale 1ns / 1ps

package dapi_pkg;

  // character code and position counter widths
  localparam int CHAR_W = 8;
  localparam int POS_W  = 8;

  // magnitude never exceeds 2^31 - 1, so 31 bits hold it
  localparam int MAG_W   = 31;
  localparam int VALUE_W = 32;

  localparam int MAX_CHARS_DEF = 255;

  localparam logic [MAG_W-1:0] LIMIT_MAG = 31'h7fff_ffff;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    STATUS_OK  = 2'd0,
    STATUS_NAN = 2'd1,
    STATUS_OVF = 2'd2
  } status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } char_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
  } result_t;

endpackage

// ----- hdl/dapi_in_reg.sv -----
// input register stage of the parser
`timescale 1ns / 1ps

module dapi_in_reg
  import dapi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_stall,
  input  char_req_t char_req,
  input  logic      advance,
  output logic      held_valid,
  output char_req_t held_req
);

  logic      valid;
  char_req_t req;
  logic      accept;

  // stage is freed in the same cycle it advances
  assign char_stall = valid & ~advance;
  assign accept     = char_valid & ~char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= char_req;
    end
  end

  assign held_valid = valid;
  assign held_req   = req;

endmodule

// ----- hdl/dapi_core.sv -----
// parse state registers and per-character update logic
`timescale 1ns / 1ps

module dapi_core
  import dapi_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  char_req_t req,
  output result_t   result
);

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_CHARS);

  logic [MAG_W-1:0] magnitude_acc, magnitude_acc_next;
  logic             negative_flag, negative_flag_next;
  logic [POS_W-1:0] char_position, char_position_next;
  logic             seen_dot, seen_dot_next;
  status_t          error_code, error_code_next;

  logic             take;
  logic [3:0]       digit;
  logic [MAG_W+3:0] mag_x10;
  logic [MAG_W+3:0] mag_sum;
  logic [VALUE_W-1:0] mag_ext;

  assign take    = (char_position < POS_LIMIT);
  assign digit   = 4'(req.char_code - CHAR_ZERO);
  assign mag_x10 = {1'b0, magnitude_acc, 3'b000} + {3'b000, magnitude_acc, 1'b0};
  assign mag_sum = mag_x10 + {{MAG_W{1'b0}}, digit};

  always_comb begin
    magnitude_acc_next = magnitude_acc;
    negative_flag_next = negative_flag;
    char_position_next = char_position;
    seen_dot_next      = seen_dot;
    error_code_next    = error_code;
    if (take) begin
      char_position_next = char_position + POS_W'(1);
      if (req.char_code == CHAR_MINUS && char_position == '0) begin
        negative_flag_next = 1'b1;
      end else if (req.char_code == CHAR_DOT) begin
        if (seen_dot) begin
          error_code_next = STATUS_NAN;
        end
        seen_dot_next = 1'b1;
      end else if (req.char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
        if (seen_dot) begin
          if (req.char_code != CHAR_ZERO) begin
            error_code_next = STATUS_NAN;
          end
        end else if (error_code == STATUS_OK) begin
          // true magnitude check on the widened product
          if (mag_sum > {4'b0000, LIMIT_MAG}) begin
            error_code_next = STATUS_OVF;
          end else begin
            magnitude_acc_next = mag_sum[MAG_W-1:0];
          end
        end
      end else begin
        error_code_next = STATUS_NAN;
      end
    end
  end

  // result built from the state after this character
  always_comb begin
    mag_ext       = {1'b0, magnitude_acc_next};
    result.status = error_code_next;
    if (error_code_next != STATUS_OK) begin
      result.value = '0;
    end else if (negative_flag_next) begin
      result.value = VALUE_W'(-mag_ext);
    end else begin
      result.value = mag_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && req.last_char)) begin
      magnitude_acc <= '0;
      negative_flag <= 1'b0;
      char_position <= '0;
      seen_dot      <= 1'b0;
      error_code    <= STATUS_OK;
    end else if (fire) begin
      magnitude_acc <= magnitude_acc_next;
      negative_flag <= negative_flag_next;
      char_position <= char_position_next;
      seen_dot      <= seen_dot_next;
      error_code    <= error_code_next;
    end
  end

  ap_pos_bound: assert property (@(posedge clk) disable iff (rst)
    char_position <= POS_LIMIT)
    else $error("char position ran past limit");

  ap_ovf_freeze: assert property (@(posedge clk) disable iff (rst)
    (error_code != STATUS_OK) |=> $stable(magnitude_acc) || $past(fire && req.last_char))
    else $error("magnitude changed after error");

endmodule

// ----- hdl/dapi_out_reg.sv -----
// result register of the parser
`timescale 1ns / 1ps

module dapi_out_reg
  import dapi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  output logic    free,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result_out
);

  logic    valid;
  result_t data;

  assign free = ~valid | ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!result_stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result_in;
    end
  end

  assign result_valid = valid;
  assign result_out   = data;

endmodule

// ----- hdl/decimal_ascii_to_int_parser_unit.sv -----
// top level of the decimal text to signed integer parser
`timescale 1ns / 1ps

// streaming parser of signed decimal text: one ascii character per request,
// last_char marks the end of a string and produces one result (parsed_value
// and parse_status: ok, not a number, overflow); other characters produce
// none. a new character is taken every cycle unless char_stall holds it:
// an accepted character goes through the input register, then through the
// digit update (a x10 shift-add, digit add and limit compare) into the
// result register. the result register frees the input side, so only a
// final character waits while an older result is stalled. magnitudes above
// 2147483647, including "-2147483648", give overflow; characters past
// MAX_CHARS are ignored but a last mark still ends the string.

module decimal_ascii_to_int_parser_unit
  import dapi_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // character request channel
  input  logic                      char_valid,
  output logic                      char_stall,
  input  logic [CHAR_W-1:0]         char_code,
  input  logic                      last_char,
  // result channel
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [VALUE_W-1:0] parsed_value,
  output logic [1:0]                parse_status
);

  char_req_t in_req;
  char_req_t held_req;
  logic      held_valid;
  logic      out_free;
  logic      fire;
  logic      load;
  result_t   core_result;
  result_t   out_result;

  assign in_req.char_code = char_code;
  assign in_req.last_char = last_char;

  // a final character needs room in the result register, others never wait
  assign fire = held_valid & (~held_req.last_char | out_free);
  assign load = fire & held_req.last_char;

  dapi_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_req   (in_req),
    .advance    (fire),
    .held_valid (held_valid),
    .held_req   (held_req)
  );

  dapi_core #(
    .MAX_CHARS (MAX_CHARS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .req    (held_req),
    .result (core_result)
  );

  dapi_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .result_in    (core_result),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_out   (out_result)
  );

  assign parsed_value = out_result.value;
  assign parse_status = out_result.status;

  // error results always carry a zero value
  ap_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && parse_status != STATUS_OK) |-> (parsed_value == '0))
    else $error("error result with nonzero value");

  // most negative value is never reachable
  ap_no_min: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (parsed_value != {1'b1, {(VALUE_W-1){1'b0}}}))
    else $error("most negative value produced");

  // input side only stalls on a waiting final character
  ap_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> (held_valid && held_req.last_char && result_valid && result_stall))
    else $error("input stalled without cause");

endmodule
